>>> sv/boot_sector_partition_locator_assert.svh
// Assertion macros used by the port-level checker of the boot sector partition locator.
`ifndef BOOT_SECTOR_PARTITION_LOCATOR_ASSERT_SVH
`define BOOT_SECTOR_PARTITION_LOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define BSPL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define BSPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bspl_pkg.sv
// Package of the boot sector partition locator: constants, types and helper functions.
package bspl_pkg;

    localparam int SECTOR_BYTES  = 512;
    localparam int TABLE_ENTRIES = 4;
    localparam int TABLE_BASE    = 446;
    localparam int ENTRY_BYTES   = 16;

    localparam logic [8:0] FIRST_OFFSET      = 9'd0;
    localparam logic [8:0] LAST_OFFSET       = 9'(SECTOR_BYTES - 1);
    localparam logic [8:0] SIG_OFFSET        = 9'(SECTOR_BYTES - 2);
    localparam logic [8:0] MAGIC_LOW_OFFSET  = 9'd56;
    localparam logic [8:0] MAGIC_HIGH_OFFSET = 9'd57;
    localparam logic [8:0] TABLE_FIRST       = 9'(TABLE_BASE);
    localparam logic [8:0] TABLE_END         = 9'(TABLE_BASE + TABLE_ENTRIES * ENTRY_BYTES);

    // Byte positions inside one partition table entry.
    localparam logic [3:0] ENTRY_TYPE_POS = 4'd4;
    localparam logic [3:0] ENTRY_LAST_POS = 4'(ENTRY_BYTES - 1);
    localparam logic [1:0] ENTRY_START_GRP  = 2'b10;
    localparam logic [1:0] ENTRY_LENGTH_GRP = 2'b11;

    localparam logic [7:0] MAGIC_LOW  = 8'h53;
    localparam logic [7:0] MAGIC_HIGH = 8'hEF;
    localparam logic [7:0] SIG_FIRST  = 8'h55;
    localparam logic [7:0] SIG_SECOND = 8'hAA;
    localparam logic [7:0] LINUX_TYPE = 8'h83;

    localparam logic [31:0] MIN_DEVICE  = 32'd4;
    localparam logic [31:0] DEFAULT_CAP = 32'd4096;

    localparam logic KIND_SUPER = 1'b0;
    localparam logic KIND_MBR   = 1'b1;

    typedef enum logic [2:0] {
        ST_RAW_EXT2 = 3'd0,
        ST_NEED_MBR = 3'd1,
        ST_PART     = 3'd2,
        ST_WHOLE    = 3'd3,
        ST_REJECT   = 3'd4
    } status_t;

    typedef enum logic {
        REG_DEVICE_SECTORS = 1'b0,
        REG_SECTOR_CAP     = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [8:0] byte_offset;
        logic       sector_kind;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] start_offset;
        logic [31:0] usable_sectors;
    } result_t;

    typedef struct packed {
        logic [31:0] device_sectors;
        logic [31:0] sector_cap;
    } settings_t;

    // Replaces one byte lane of a little-endian word.
    function automatic logic [31:0] put_lane(input logic [31:0] word, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = word;
        case (lane)
            2'd0:    r[7:0]   = b;
            2'd1:    r[15:8]  = b;
            2'd2:    r[23:16] = b;
            default: r[31:24] = b;
        endcase
        return r;
    endfunction

endpackage

>>> sv/bspl_in_if.sv
// Channel that carries sector bytes into the locator.
interface bspl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [8:0] byte_offset;
    logic       sector_kind;

    modport source (output valid, output data_byte, output byte_offset, output sector_kind,
                    input ready);
    modport sink (input valid, input data_byte, input byte_offset, input sector_kind,
                  output ready);
endinterface

>>> sv/bspl_out_if.sv
// Channel that carries locator results out of the block.
interface bspl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] start_offset;
    logic [31:0] usable_sectors;

    modport source (output valid, output status, output start_offset, output usable_sectors,
                    input ready);
    modport sink (input valid, input status, input start_offset, input usable_sectors,
                  output ready);
endinterface

>>> sv/bspl_cfg_if.sv
// Channel that writes the configuration registers of the locator.
interface bspl_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/bspl_cfg_regs.sv
// Configuration register file of the locator.
module bspl_cfg_regs
    import bspl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bspl_cfg_if.sink   cfg,
    output settings_t  settings
);

    settings_t settings_reg;

    assign cfg.ready = 1'b1;
    assign settings  = settings_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg.device_sectors <= '0;
            settings_reg.sector_cap     <= DEFAULT_CAP;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_DEVICE_SECTORS: settings_reg.device_sectors <= cfg.data;
                REG_SECTOR_CAP:     settings_reg.sector_cap     <= cfg.data;
                default:            ;
            endcase
        end
    end

endmodule

>>> sv/bspl_in_stage.sv
// Input register of the locator: holds one accepted byte until the parser takes it.
module bspl_in_stage
    import bspl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bspl_in_if.sink   sector_in,
    input  logic      advance,
    output logic      item_valid,
    output item_t     item
);

    logic  valid_reg;
    item_t item_reg;
    logic  load;

    assign sector_in.ready = !valid_reg || advance;
    assign load            = sector_in.valid && sector_in.ready;
    assign item_valid      = valid_reg;
    assign item            = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte   <= sector_in.data_byte;
            item_reg.byte_offset <= sector_in.byte_offset;
            item_reg.sector_kind <= sector_in.sector_kind;
        end
    end

endmodule

>>> sv/bspl_parser.sv
// Sector parser: capture state for both sector kinds and the end-of-sector verdict.
module bspl_parser
    import bspl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  item_t      item,
    input  settings_t  settings,
    input  logic       out_free,
    output logic       advance,
    output logic       res_valid,
    output result_t    res
);

    logic [7:0]  magic_low_reg,  magic_low_next;
    logic [7:0]  magic_high_reg, magic_high_next;
    logic [7:0]  entry_type_reg, entry_type_next;
    logic [31:0] entry_start_reg, entry_start_next;
    logic [31:0] entry_length_reg, entry_length_next;
    logic        match_found_reg, match_found_next;
    logic        match_invalid_reg, match_invalid_next;
    logic [31:0] found_start_reg, found_start_next;
    logic [31:0] found_length_reg, found_length_next;
    logic        sig_first_ok_reg, sig_first_ok_next;

    logic        is_last;
    logic        restart;
    logic        in_table;
    logic [8:0]  table_rel;
    logic [3:0]  pos;
    logic [31:0] dev;
    logic        small_device;
    logic        len_en;
    logic [31:0] len_src;

    assign dev       = settings.device_sectors;
    assign is_last   = item.byte_offset == LAST_OFFSET;
    assign restart   = item.byte_offset == FIRST_OFFSET;
    assign in_table  = item.byte_offset >= TABLE_FIRST && item.byte_offset < TABLE_END;
    assign table_rel = item.byte_offset - TABLE_FIRST;
    assign pos       = table_rel[3:0];
    assign advance   = item_valid && (!is_last || out_free);
    assign res_valid = advance && is_last;
    assign small_device = dev < MIN_DEVICE;

    // Capture updates. The offset-zero byte clears its own kind before anything else.
    always_comb
    begin
        magic_low_next     = magic_low_reg;
        magic_high_next    = magic_high_reg;
        entry_type_next    = entry_type_reg;
        entry_start_next   = entry_start_reg;
        entry_length_next  = entry_length_reg;
        match_found_next   = match_found_reg;
        match_invalid_next = match_invalid_reg;
        found_start_next   = found_start_reg;
        found_length_next  = found_length_reg;
        sig_first_ok_next  = sig_first_ok_reg;

        if (item.sector_kind == KIND_SUPER)
        begin
            if (restart)
            begin
                magic_low_next  = '0;
                magic_high_next = '0;
            end
            if (item.byte_offset == MAGIC_LOW_OFFSET)
            begin
                magic_low_next = item.data_byte;
            end
            if (item.byte_offset == MAGIC_HIGH_OFFSET)
            begin
                magic_high_next = item.data_byte;
            end
        end
        else
        begin
            if (restart)
            begin
                entry_type_next    = '0;
                entry_start_next   = '0;
                entry_length_next  = '0;
                match_found_next   = 1'b0;
                match_invalid_next = 1'b0;
                found_start_next   = '0;
                found_length_next  = '0;
                sig_first_ok_next  = 1'b0;
            end
            if (in_table)
            begin
                if (pos == ENTRY_TYPE_POS)
                begin
                    entry_type_next = item.data_byte;
                end
                else if (pos[3:2] == ENTRY_START_GRP)
                begin
                    entry_start_next = put_lane(entry_start_next, pos[1:0], item.data_byte);
                end
                else if (pos[3:2] == ENTRY_LENGTH_GRP)
                begin
                    entry_length_next = put_lane(entry_length_next, pos[1:0], item.data_byte);
                end
                // The first Linux entry is latched and judged against the device size
                // as it stands when the entry's last byte arrives.
                if (pos == ENTRY_LAST_POS && !match_found_next &&
                    entry_type_next == LINUX_TYPE)
                begin
                    match_found_next   = 1'b1;
                    found_start_next   = entry_start_next;
                    found_length_next  = entry_length_next;
                    match_invalid_next = entry_start_next == '0 || entry_length_next == '0 ||
                                         entry_start_next >= dev ||
                                         entry_length_next > dev - entry_start_next;
                end
            end
            if (item.byte_offset == SIG_OFFSET)
            begin
                sig_first_ok_next = item.data_byte == SIG_FIRST;
            end
        end
    end

    // Verdict at the last byte. That byte touches no capture, so the stored state is final.
    always_comb
    begin
        res.status       = ST_REJECT;
        res.start_offset = '0;
        len_en           = 1'b0;
        len_src          = dev;
        if (small_device)
        begin
            res.status = ST_REJECT;
        end
        else if (item.sector_kind == KIND_SUPER)
        begin
            if (magic_low_reg == MAGIC_LOW && magic_high_reg == MAGIC_HIGH)
            begin
                res.status = ST_RAW_EXT2;
                len_en     = 1'b1;
            end
            else
            begin
                res.status = ST_NEED_MBR;
            end
        end
        else if (!(sig_first_ok_reg && item.data_byte == SIG_SECOND))
        begin
            res.status = ST_WHOLE;
            len_en     = 1'b1;
        end
        else if (!match_found_reg || match_invalid_reg)
        begin
            res.status = ST_REJECT;
        end
        else
        begin
            res.status       = ST_PART;
            res.start_offset = found_start_reg;
            len_src          = found_length_reg;
            len_en           = 1'b1;
        end

        if (!len_en)
        begin
            res.usable_sectors = '0;
        end
        else if (len_src > settings.sector_cap)
        begin
            res.usable_sectors = settings.sector_cap;
        end
        else
        begin
            res.usable_sectors = len_src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_low_reg     <= '0;
            magic_high_reg    <= '0;
            entry_type_reg    <= '0;
            entry_start_reg   <= '0;
            entry_length_reg  <= '0;
            match_found_reg   <= 1'b0;
            match_invalid_reg <= 1'b0;
            found_start_reg   <= '0;
            found_length_reg  <= '0;
            sig_first_ok_reg  <= 1'b0;
        end
        else if (advance)
        begin
            magic_low_reg     <= magic_low_next;
            magic_high_reg    <= magic_high_next;
            entry_type_reg    <= entry_type_next;
            entry_start_reg   <= entry_start_next;
            entry_length_reg  <= entry_length_next;
            match_found_reg   <= match_found_next;
            match_invalid_reg <= match_invalid_next;
            found_start_reg   <= found_start_next;
            found_length_reg  <= found_length_next;
            sig_first_ok_reg  <= sig_first_ok_next;
        end
    end

endmodule

>>> sv/bspl_out_stage.sv
// Result register of the locator: holds one result word until the consumer takes it.
module bspl_out_stage
    import bspl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    input  result_t    res,
    output logic       out_free,
    bspl_out_if.source result
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free              = !valid_reg || result.ready;
    assign result.valid          = valid_reg;
    assign result.status         = res_reg.status;
    assign result.start_offset   = res_reg.start_offset;
    assign result.usable_sectors = res_reg.usable_sectors;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> sv/boot_sector_partition_locator.sv
// Top level of the boot sector partition locator.
//
// The block takes the bytes of two 512-byte sectors, one word per byte, each tagged with
// its offset and its kind: kind 0 is LBA 2 (a possible ext2 superblock), kind 1 is LBA 0
// (a possible MBR). Only the word at offset 511 of either kind produces a result word;
// every other byte is simply absorbed into the capture state. For the superblock sector
// the result is raw ext2 (status 0, whole device) when the magic 0xEF53 sits at offsets
// 56 and 57, otherwise "need MBR sector" (status 1). For the MBR sector a missing 55AA
// signature gives status 3 (no table, whole device); with the signature, the first entry
// of type 0x83 is reported as status 2 with its start and clamped length, provided its
// start and length are non-zero and fit inside device_sectors; otherwise status 4. A
// device of fewer than four sectors always gives status 4. Usable sector counts are
// clamped to sector_cap. A byte at offset 0 restarts the captures of its own kind.
// Throughput is one byte per clock while the result register has room: the parsing is a
// single pass of logic between an input register and a result register, so the last byte
// of a sector is held in the input register and its result word is then offered from the
// result register. When the result register is still occupied, a last-byte word waits in
// the input register, and no further byte is accepted until it has moved on. Configuration
// is written through its own channel, which is always ready; it should only be written
// while no sector byte is in flight.
module boot_sector_partition_locator
    import bspl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bspl_cfg_if.sink    cfg,
    bspl_in_if.sink     sector_in,
    bspl_out_if.source  result
);

    settings_t settings;
    logic      advance;
    logic      item_valid;
    item_t     item;
    logic      out_free;
    logic      res_valid;
    result_t   res;

    // Register file for device_sectors and sector_cap.
    bspl_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    // Input register: accepts a new byte whenever it is empty or the held one moves on this cycle.
    bspl_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .sector_in  (sector_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Capture state and verdict logic; only a last byte needs room in the result register.
    bspl_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .settings   (settings),
        .out_free   (out_free),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result register towards the consumer.
    bspl_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .result    (result)
    );

endmodule

>>> sv/bspl_checker.sv
// Port-level checker of the boot sector partition locator and its bind statement.
`include "boot_sector_partition_locator_assert.svh"

module bspl_checker
    import bspl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    bspl_in_if.sink    sector_in,
    bspl_out_if.source result
);

    `BSPL_ASSERT_NEXT(a_result_held, result.valid && !result.ready, result.valid, "result word withdrawn while stalled")
    `BSPL_ASSERT_SAME(a_no_region, result.valid && (result.status == ST_REJECT || result.status == ST_NEED_MBR), result.usable_sectors == '0 && result.start_offset == '0, "rejected or pending result carries a region")
    `BSPL_ASSERT_SAME(a_start_only_part, result.valid && result.status != ST_PART, result.start_offset == '0, "start offset set without a partition")
    `BSPL_ASSERT_SAME(a_result_from_last, $rose(result.valid), $past(sector_in.valid && sector_in.ready && sector_in.byte_offset == LAST_OFFSET, 2), "result word without a last sector byte")

endmodule

bind boot_sector_partition_locator bspl_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sector_in (sector_in),
    .result    (result)
);
